### design/assert_macros.svh
// Assertion shorthands used by the replacement engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define MQ_ASSERT(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("mq assertion failed");

// A condition that implies another one on the next clock edge.
`define MQ_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("mq assertion failed");

`endif

### design/mqcr_pkg.sv
package mqcr_pkg;

  localparam int KEY_W     = 64;
  localparam int FREQ_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 11;
  localparam int OUT_W     = 24;

  localparam logic [FREQ_W-1:0] FREQ_MAX = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] REG_GHOST_CAP = 3'd4;

  localparam logic [10:0] REAL_CAP_MAX  = 11'd1024;
  localparam logic [10:0] GHOST_CAP_MAX = 11'd512;

  localparam logic OP_READ = 1'b0;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_UNLK_RD,
    S_UNLK_WP,
    S_UNLK_WN,
    S_ALLOC,
    S_FREE_RD,
    S_POP_RD,
    S_POP_UPD,
    S_WRDATA,
    S_CHK,
    S_PUSH,
    S_PUSH2,
    S_POST,
    S_DONE
  } state_e;

endpackage

### design/mqcr_ram.sv
module mqcr_ram #(
  parameter int DEPTH = 1536,
  parameter int AW    = 11,
  parameter int DW    = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wmask_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      for (int i = 0; i < DW; i++) begin
        if (wmask_i[i]) begin
          mem[waddr_i][i] <= wdata_i[i];
        end
      end
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### design/multi_queue_cache_replacement.sv
// Multi-queue cache replacement engine.
// Requests arrive on the slave stream: tdata carries the 64-bit block key and
// tuser the request kind (0 read, 1 write). Writes are dropped without a
// result. Each read yields one result transfer on the master stream.
// The per-entry keys, frequencies and queue tags sit in one memory and the
// doubly linked queue pointers in a second; both have registered reads.
// A read first scans the occupied part of the entry pool, one entry a cycle,
// up to the number of entries ever allocated. A hit is then unlinked from
// its queue, and the eviction cascade moves the head of each full queue down
// one level, freeing it from the ghost queue. The result is offered from the
// done state, and the next request is taken only back in the idle state;
// requests are handled one at a time.
// Queue capacities are to be written on the configuration channel only while
// idle; the block itself does not enforce this. The channel is always ready.
// After reset all queues are empty and the capacities are 256 for the real
// queues and 512 for the ghost queue; no clearing pass is needed.
// A finished result waits in an output register, so a new request is taken
// while the receiver stalls; the next result then waits until that transfer.
module multi_queue_cache_replacement
  import mqcr_pkg::*;
#(
  parameter int NUM_QUEUES = 4,
  parameter int CAPACITY   = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [KEY_W-1:0]     s_axis_tdata,   // block_key
  input  logic                 s_axis_tuser,   // op
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // hit, ghost_hit, found_queue[2:0], new_frequency[15:0], placed_queue[2:0]
  output logic [OUT_W-1:0]     m_axis_tdata,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

`include "assert_macros.svh"

  localparam int POOL = CAPACITY + CAPACITY / 2;
  localparam int IW   = $clog2(POOL + 1);
  localparam int AW   = $clog2(POOL);
  localparam int QW   = $clog2(NUM_QUEUES + 1);
  localparam int NQ1  = NUM_QUEUES + 1;
  localparam int DW   = 1 + QW + FREQ_W + KEY_W;
  localparam int LW   = 2 * IW;
  localparam logic [IW-1:0] NIL = IW'(POOL);
  localparam logic [QW-1:0] QTOP = QW'(NUM_QUEUES);

  state_e st_q, st_d;

  logic [IW-1:0] fill_q, fill_d, free_q, free_d;
  logic [IW-1:0] heads_q [NQ1];
  logic [IW-1:0] heads_d [NQ1];
  logic [IW-1:0] tails_q [NQ1];
  logic [IW-1:0] tails_d [NQ1];
  logic [IW-1:0] sizes_q [NQ1];
  logic [IW-1:0] sizes_d [NQ1];
  logic [10:0]   cap_q [4];
  logic [9:0]    gcap_q;
  logic          out_valid_q, out_valid_d;
  logic [OUT_W-1:0] out_q, out_d;

  logic [KEY_W-1:0]  key_q, key_d;
  logic [IW-1:0]     e_q, e_d, cur_q, cur_d, ev_q, ev_d, sidx_q, sidx_d, paddr_q, paddr_d;
  logic [IW-1:0]     p_q, p_d, n_q, n_d, otail_q, otail_d;
  logic              svld_q, svld_d, hit_q, hit_d, ghost_q, ghost_d, ctx_q, ctx_d;
  logic [QW-1:0]     fq_q, fq_d, pq_q, pq_d, cq_q, cq_d, pos_q, pos_d;
  logic [FREQ_W-1:0] cnt_q, cnt_d;

  logic          d_we, l_we;
  logic [AW-1:0] d_waddr, d_raddr, l_waddr, l_raddr;
  logic [DW-1:0] d_wmask, d_wdata, d_rdata;
  logic [LW-1:0] l_wmask, l_wdata, l_rdata;

  logic [KEY_W-1:0]  dr_key;
  logic [FREQ_W-1:0] dr_cnt;
  logic [QW-1:0]     dr_qid;
  logic              dr_vld;
  logic [IW-1:0]     lr_next;

  logic [10:0]   cap_raw, cap_lim, cap_c;
  logic [QW-1:0] cqm1;
  logic          full_c;
  logic [QW-1:0] pos_c;
  logic [4:0]    msb_c;
  logic [QW-1:0] low_q_c;

  assign dr_key  = d_rdata[KEY_W-1:0];
  assign dr_cnt  = d_rdata[KEY_W+FREQ_W-1:KEY_W];
  assign dr_qid  = d_rdata[KEY_W+FREQ_W+QW-1:KEY_W+FREQ_W];
  assign dr_vld  = d_rdata[DW-1];
  assign lr_next = l_rdata[IW-1:0];

  mqcr_ram #(.DEPTH(POOL), .AW(AW), .DW(DW)) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .waddr_i (d_waddr),
    .wmask_i (d_wmask),
    .wdata_i (d_wdata),
    .raddr_i (d_raddr),
    .rdata_o (d_rdata)
  );

  mqcr_ram #(.DEPTH(POOL), .AW(AW), .DW(LW)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (l_waddr),
    .wmask_i (l_wmask),
    .wdata_i (l_wdata),
    .raddr_i (l_raddr),
    .rdata_o (l_rdata)
  );

  assign cqm1 = cq_q - QW'(1);

  always_comb begin
    if (cq_q == '0) begin
      cap_raw = {1'b0, gcap_q};
      cap_lim = GHOST_CAP_MAX;
    end else begin
      cap_raw = (int'(cq_q) <= 4) ? cap_q[cqm1[1:0]] : cap_q[3];
      cap_lim = REAL_CAP_MAX;
    end
    if (cap_raw == '0) begin
      cap_c = 11'd1;
    end else if (cap_raw > cap_lim) begin
      cap_c = cap_lim;
    end else begin
      cap_c = cap_raw;
    end
  end

  assign full_c = 32'(sizes_q[cq_q]) >= 32'(cap_c);

  always_comb begin
    msb_c = '0;
    for (int i = 0; i < FREQ_W; i++) begin
      if (cnt_q[i]) begin
        msb_c = 5'(i);
      end
    end
    if (int'(msb_c) + 1 > NUM_QUEUES) begin
      pos_c = QTOP;
    end else begin
      pos_c = QW'(msb_c + 5'd1);
    end
  end

  always_comb begin
    low_q_c = '0;
    for (int q = NUM_QUEUES; q >= 0; q--) begin
      if (heads_q[q] != NIL) begin
        low_q_c = QW'(q);
      end
    end
  end

  always_comb begin
    st_d        = st_q;
    fill_d      = fill_q;
    free_d      = free_q;
    heads_d     = heads_q;
    tails_d     = tails_q;
    sizes_d     = sizes_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    key_d       = key_q;
    e_d         = e_q;
    cur_d       = cur_q;
    ev_d        = ev_q;
    sidx_d      = sidx_q;
    paddr_d     = paddr_q;
    p_d         = p_q;
    n_d         = n_q;
    otail_d     = otail_q;
    svld_d      = 1'b0;
    hit_d       = hit_q;
    ghost_d     = ghost_q;
    ctx_d       = ctx_q;
    fq_d        = fq_q;
    pq_d        = pq_q;
    cq_d        = cq_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    d_we        = 1'b0;
    d_waddr     = e_q[AW-1:0];
    d_wmask     = '0;
    d_wdata     = '0;
    d_raddr     = sidx_q[AW-1:0];
    l_we        = 1'b0;
    l_waddr     = cur_q[AW-1:0];
    l_wmask     = '0;
    l_wdata     = '0;
    l_raddr     = e_q[AW-1:0];
    s_axis_tready = (st_q == S_IDLE);

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (st_q)
      S_IDLE: begin
        if (s_axis_tvalid && s_axis_tuser == OP_READ) begin
          key_d  = s_axis_tdata;
          sidx_d = '0;
          st_d   = S_SCAN;
        end
      end
      S_SCAN: begin
        if (svld_q && dr_vld && dr_key == key_q) begin
          e_d     = paddr_q;
          fq_d    = dr_qid;
          hit_d   = (dr_qid != '0);
          ghost_d = (dr_qid == '0);
          cnt_d   = (dr_cnt == FREQ_MAX) ? FREQ_MAX : dr_cnt + FREQ_W'(1);
          st_d    = S_UNLK_RD;
        end else if (sidx_q < fill_q) begin
          svld_d  = 1'b1;
          paddr_d = sidx_q;
          sidx_d  = sidx_q + IW'(1);
        end else begin
          hit_d   = 1'b0;
          ghost_d = 1'b0;
          fq_d    = '0;
          cnt_d   = FREQ_W'(1);
          st_d    = S_ALLOC;
        end
      end
      S_UNLK_RD: begin
        l_raddr = e_q[AW-1:0];
        st_d    = S_UNLK_WP;
      end
      S_UNLK_WP: begin
        p_d = l_rdata[LW-1:IW];
        n_d = lr_next;
        if (l_rdata[LW-1:IW] == NIL) begin
          heads_d[fq_q] = lr_next;
        end else begin
          l_we    = 1'b1;
          l_waddr = l_rdata[LW-1:IW][AW-1:0];
          l_wmask = {{IW{1'b0}}, {IW{1'b1}}};
          l_wdata = {{IW{1'b0}}, lr_next};
        end
        st_d = S_UNLK_WN;
      end
      S_UNLK_WN: begin
        if (n_q == NIL) begin
          tails_d[fq_q] = p_q;
        end else begin
          l_we    = 1'b1;
          l_waddr = n_q[AW-1:0];
          l_wmask = {{IW{1'b1}}, {IW{1'b0}}};
          l_wdata = {p_q, {IW{1'b0}}};
        end
        sizes_d[fq_q] = sizes_q[fq_q] - IW'(1);
        st_d = S_WRDATA;
      end
      S_ALLOC: begin
        if (free_q != NIL) begin
          e_d     = free_q;
          l_raddr = free_q[AW-1:0];
          st_d    = S_FREE_RD;
        end else if (fill_q < NIL) begin
          e_d    = fill_q;
          fill_d = fill_q + IW'(1);
          st_d   = S_WRDATA;
        end else begin
          pq_d  = low_q_c;
          ctx_d = 1'b0;
          st_d  = S_POP_RD;
        end
      end
      S_FREE_RD: begin
        free_d = lr_next;
        st_d   = S_WRDATA;
      end
      S_POP_RD: begin
        l_raddr = heads_q[pq_q][AW-1:0];
        st_d    = S_POP_UPD;
      end
      S_POP_UPD: begin
        ev_d          = heads_q[pq_q];
        heads_d[pq_q] = lr_next;
        if (lr_next == NIL) begin
          tails_d[pq_q] = NIL;
        end else begin
          l_we    = 1'b1;
          l_waddr = lr_next[AW-1:0];
          l_wmask = {{IW{1'b1}}, {IW{1'b0}}};
          l_wdata = {NIL, {IW{1'b0}}};
        end
        sizes_d[pq_q] = sizes_q[pq_q] - IW'(1);
        if (ctx_q) begin
          st_d = S_PUSH;
        end else begin
          e_d  = heads_q[pq_q];
          st_d = S_WRDATA;
        end
      end
      S_WRDATA: begin
        d_we    = 1'b1;
        d_waddr = e_q[AW-1:0];
        d_wmask = {1'b1, {QW{1'b0}}, {(FREQ_W + KEY_W){1'b1}}};
        d_wdata = {1'b1, {QW{1'b0}}, cnt_q, key_q};
        cur_d   = e_q;
        cq_d    = pos_c;
        pos_d   = pos_c;
        st_d    = S_CHK;
      end
      S_CHK: begin
        if (full_c) begin
          pq_d  = cq_q;
          ctx_d = 1'b1;
          st_d  = S_POP_RD;
        end else begin
          ev_d = NIL;
          st_d = S_PUSH;
        end
      end
      S_PUSH: begin
        l_we    = 1'b1;
        l_waddr = cur_q[AW-1:0];
        l_wmask = '1;
        l_wdata = {tails_q[cq_q], NIL};
        d_we    = 1'b1;
        d_waddr = cur_q[AW-1:0];
        d_wmask = {1'b0, {QW{1'b1}}, {(FREQ_W + KEY_W){1'b0}}};
        d_wdata = {1'b0, cq_q, {(FREQ_W + KEY_W){1'b0}}};
        otail_d = tails_q[cq_q];
        if (tails_q[cq_q] == NIL) begin
          heads_d[cq_q] = cur_q;
          st_d = S_POST;
        end else begin
          st_d = S_PUSH2;
        end
        tails_d[cq_q] = cur_q;
        sizes_d[cq_q] = sizes_q[cq_q] + IW'(1);
      end
      S_PUSH2: begin
        l_we    = 1'b1;
        l_waddr = otail_q[AW-1:0];
        l_wmask = {{IW{1'b0}}, {IW{1'b1}}};
        l_wdata = {{IW{1'b0}}, cur_q};
        st_d    = S_POST;
      end
      S_POST: begin
        if (ev_q == NIL) begin
          st_d = S_DONE;
        end else if (cq_q == '0) begin
          d_we    = 1'b1;
          d_waddr = ev_q[AW-1:0];
          d_wmask = {1'b1, {(DW - 1){1'b0}}};
          d_wdata = '0;
          l_we    = 1'b1;
          l_waddr = ev_q[AW-1:0];
          l_wmask = {{IW{1'b0}}, {IW{1'b1}}};
          l_wdata = {{IW{1'b0}}, free_q};
          free_d  = ev_q;
          st_d    = S_DONE;
        end else begin
          cur_d = ev_q;
          cq_d  = cq_q - QW'(1);
          st_d  = S_CHK;
        end
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_d = {3'(pos_q), cnt_q, 3'(fq_q), ghost_q, hit_q};
          st_d  = S_IDLE;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      fill_q      <= '0;
      free_q      <= NIL;
      out_valid_q <= 1'b0;
      svld_q      <= 1'b0;
      for (int q = 0; q < NQ1; q++) begin
        heads_q[q] <= NIL;
        tails_q[q] <= NIL;
        sizes_q[q] <= '0;
      end
      for (int r = 0; r < 4; r++) begin
        cap_q[r] <= 11'd256;
      end
      gcap_q <= 10'd512;
    end else begin
      st_q        <= st_d;
      fill_q      <= fill_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
      svld_q      <= svld_d;
      heads_q     <= heads_d;
      tails_q     <= tails_d;
      sizes_q     <= sizes_d;
      if (cfg_valid_i) begin
        if (cfg_index_i < REG_GHOST_CAP) begin
          cap_q[cfg_index_i[1:0]] <= cfg_data_i;
        end else if (cfg_index_i == REG_GHOST_CAP) begin
          gcap_q <= cfg_data_i[9:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q   <= out_d;
    key_q   <= key_d;
    e_q     <= e_d;
    cur_q   <= cur_d;
    ev_q    <= ev_d;
    sidx_q  <= sidx_d;
    paddr_q <= paddr_d;
    p_q     <= p_d;
    n_q     <= n_d;
    otail_q <= otail_d;
    hit_q   <= hit_d;
    ghost_q <= ghost_d;
    ctx_q   <= ctx_d;
    fq_q    <= fq_d;
    pq_q    <= pq_d;
    cq_q    <= cq_d;
    pos_q   <= pos_d;
    cnt_q   <= cnt_d;
  end

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  `MQ_ASSERT(a_fill_bound, fill_q <= NIL)
  `MQ_ASSERT(a_unlink_nonempty, st_q != S_UNLK_WP || sizes_q[fq_q] != '0)
  `MQ_ASSERT(a_pop_nonempty, st_q != S_POP_RD || heads_q[pq_q] != NIL)
  `MQ_ASSERT_NEXT(a_push_tail, st_q == S_PUSH, tails_q[cq_q] == cur_q)

endmodule
